// ===== hw/rtl/mqm_pkg.sv =====
`default_nettype none
package mqm_pkg;

    localparam int POOL_NODES = 32;
    localparam int NUM_QUEUES = 8;
    localparam int PTR_W      = $clog2(POOL_NODES + 1);
    localparam int IDX_W      = $clog2(POOL_NODES);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

    typedef enum logic {
        FN_ENQUEUE = 1'b0,
        FN_DEQUEUE = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_LINK_BACK,
        S_LINK_BACK2,
        S_LINK_MID,
        S_LINK_MID2,
        S_DEQ
    } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/multi_queue_manager_sorted.sv =====
// Linked-list queue manager: a pool of nodes shared by several queues, free
// nodes held on a LIFO free list.
// Command channel: a word (func, queue_id, item_handle, item_key, item_type)
// is taken at a rising edge with start high and busy low.
// Result channel: done is high for exactly one cycle with status, out_handle
// and out_type; the receiver cannot stall it and must take it then.
// Configuration: ordered_queue_mask loads on any edge with ordered_queue_mask_we
// high; write it only while the block is idle, which the block does not check.
// Busy states (result strobe in the cycle after the last one):
//   failed command (no free node, empty queue): none, result next cycle
//   dequeue: S_DEQ
//   fifo enqueue: S_POP, S_LINK_BACK, S_LINK_BACK2 unless the queue was empty
//   ordered enqueue: as fifo into an empty queue, else S_POP, S_WALK, then
//   S_LINK_MID, S_LINK_MID2 or the fifo links; walk reads one node per cycle
// Reset: all queues empty, the free list rebuilt at once through per-node
// valid bits on the next-link store, so no clearing pass is needed.
`default_nettype none
module multi_queue_manager_sorted
    import mqm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [2:0]  queue_id,
    input  wire logic [15:0] item_handle,
    input  wire logic [30:0] item_key,
    input  wire logic [7:0]  item_type,
    input  wire logic        ordered_queue_mask_we,
    input  wire logic [7:0]  ordered_queue_mask,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      out_handle,
    output logic [7:0]       out_type
);

    function automatic logic is_node(input ptr_t p);
        return p < NIL;
    endfunction

    state_t state_reg, state_next;

    // latched command word
    logic        func_reg;
    logic [2:0]  qid_reg;
    logic [15:0] handle_reg;
    logic [30:0] key_reg;
    logic [7:0]  type_reg;

    ptr_t n_reg, n_next;
    ptr_t cur_reg, cur_next;
    ptr_t pv_reg, pv_next;
    ptr_t steps_reg, steps_next;
    ptr_t free_head_reg, free_head_next;
    ptr_t front_reg [NUM_QUEUES];
    ptr_t back_reg [NUM_QUEUES];
    logic [7:0] mask_reg;

    logic        done_reg, done_next;
    status_t     status_reg, status_next;
    logic [15:0] out_handle_reg, out_handle_next;
    logic [7:0]  out_type_reg, out_type_next;

    // queue pointer updates
    logic front_we, back_we;
    ptr_t front_wd, back_wd;

    // node memories
    ptr_t        next_mem [POOL_NODES];
    ptr_t        prev_mem [POOL_NODES];
    logic [30:0] key_mem [POOL_NODES];
    logic [15:0] handle_mem [POOL_NODES];
    logic [7:0]  type_mem [POOL_NODES];
    logic [POOL_NODES-1:0] nvalid_reg;

    idx_t        rd_addr, ra_reg;
    ptr_t        next_rd_reg, prev_rd_reg;
    logic [30:0] key_rd_reg;
    logic [15:0] handle_rd_reg;
    logic [7:0]  type_rd_reg;
    ptr_t        next_val;

    logic nx_we, pv_we, dat_we;
    idx_t nx_wa, pv_wa;
    ptr_t nx_wd, pv_wd;

    logic accept, q_in_range, q_ordered;
    ptr_t front_in, front_q, back_q;

    assign accept     = start && !busy;
    assign q_in_range = int'(queue_id) < NUM_QUEUES;
    assign front_in   = q_in_range ? front_reg[queue_id] : NIL;
    assign front_q    = front_reg[qid_reg];
    assign back_q     = back_reg[qid_reg];
    assign q_ordered  = mask_reg[qid_reg];

    // unwritten next links read as the reset free chain
    assign next_val = nvalid_reg[ra_reg] ? next_rd_reg :
                      ((ra_reg == '0) ? NIL : PTR_W'(ra_reg) - PTR_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && q_in_range)
                begin
                    if (func == FN_DEQUEUE)
                    begin
                        if (is_node(front_in))
                            state_next = S_DEQ;
                    end
                    else if (is_node(free_head_reg))
                    begin
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                if (q_ordered && is_node(front_q))
                    state_next = S_WALK;
                else
                    state_next = S_LINK_BACK;
            end
            S_WALK:
            begin
                if (key_rd_reg > key_reg)
                    state_next = S_LINK_MID;
                else if (steps_reg == NIL - PTR_W'(1) || !is_node(next_val))
                    state_next = S_LINK_BACK;
            end
            S_LINK_BACK:
            begin
                state_next = is_node(back_q) ? S_LINK_BACK2 : S_IDLE;
            end
            S_LINK_BACK2: state_next = S_IDLE;
            S_LINK_MID:   state_next = S_LINK_MID2;
            S_LINK_MID2:  state_next = S_IDLE;
            S_DEQ:        state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        n_next          = n_reg;
        cur_next        = cur_reg;
        pv_next         = pv_reg;
        steps_next      = steps_reg;
        free_head_next  = free_head_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        out_handle_next = out_handle_reg;
        out_type_next   = out_type_reg;
        front_we        = 1'b0;
        front_wd        = NIL;
        back_we         = 1'b0;
        back_wd         = NIL;
        rd_addr         = '0;
        nx_we           = 1'b0;
        nx_wa           = '0;
        nx_wd           = NIL;
        pv_we           = 1'b0;
        pv_wa           = '0;
        pv_wd           = NIL;
        dat_we          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_handle_next = '0;
                    out_type_next   = '0;
                    if (func == FN_DEQUEUE)
                    begin
                        n_next  = front_in;
                        rd_addr = front_in[IDX_W-1:0];
                        if (!is_node(front_in))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                        end
                    end
                    else
                    begin
                        n_next  = free_head_reg;
                        rd_addr = free_head_reg[IDX_W-1:0];
                        if (!q_in_range || !is_node(free_head_reg))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NO_FREE;
                        end
                    end
                end
            end
            S_POP:
            begin
                free_head_next = next_val;
                dat_we         = 1'b1;
                cur_next       = front_q;
                steps_next     = '0;
                rd_addr        = front_q[IDX_W-1:0];
            end
            S_WALK:
            begin
                if (key_rd_reg > key_reg)
                begin
                    pv_next = prev_rd_reg;
                end
                else
                begin
                    cur_next   = next_val;
                    steps_next = steps_reg + PTR_W'(1);
                    rd_addr    = next_val[IDX_W-1:0];
                end
            end
            S_LINK_BACK:
            begin
                pv_we   = 1'b1;
                pv_wa   = n_reg[IDX_W-1:0];
                pv_wd   = back_q;
                nx_we   = 1'b1;
                nx_wa   = n_reg[IDX_W-1:0];
                nx_wd   = NIL;
                pv_next = back_q;
                back_we = 1'b1;
                back_wd = n_reg;
                if (!is_node(back_q))
                begin
                    front_we    = 1'b1;
                    front_wd    = n_reg;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                end
            end
            S_LINK_BACK2:
            begin
                nx_we       = 1'b1;
                nx_wa       = pv_reg[IDX_W-1:0];
                nx_wd       = n_reg;
                done_next   = 1'b1;
                status_next = ST_OK;
            end
            S_LINK_MID:
            begin
                nx_we = 1'b1;
                nx_wa = n_reg[IDX_W-1:0];
                nx_wd = cur_reg;
                pv_we = 1'b1;
                pv_wa = n_reg[IDX_W-1:0];
                pv_wd = pv_reg;
            end
            S_LINK_MID2:
            begin
                pv_we = 1'b1;
                pv_wa = cur_reg[IDX_W-1:0];
                pv_wd = n_reg;
                if (is_node(pv_reg))
                begin
                    nx_we = 1'b1;
                    nx_wa = pv_reg[IDX_W-1:0];
                    nx_wd = n_reg;
                end
                else
                begin
                    front_we = 1'b1;
                    front_wd = n_reg;
                end
                done_next   = 1'b1;
                status_next = ST_OK;
            end
            S_DEQ:
            begin
                out_handle_next = handle_rd_reg;
                out_type_next   = type_rd_reg;
                front_we        = 1'b1;
                front_wd        = next_val;
                if (is_node(next_val))
                begin
                    pv_we = 1'b1;
                    pv_wa = next_val[IDX_W-1:0];
                    pv_wd = NIL;
                end
                else
                begin
                    back_we = 1'b1;
                    back_wd = NIL;
                end
                nx_we          = 1'b1;
                nx_wa          = n_reg[IDX_W-1:0];
                nx_wd          = free_head_reg;
                free_head_next = n_reg;
                done_next      = 1'b1;
                status_next    = ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= NIL - PTR_W'(1);
            mask_reg      <= 8'd1;
            done_reg      <= 1'b0;
            nvalid_reg    <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                front_reg[i] <= NIL;
                back_reg[i]  <= NIL;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            done_reg      <= done_next;
            if (ordered_queue_mask_we)
                mask_reg <= ordered_queue_mask;
            if (nx_we)
                nvalid_reg[nx_wa] <= 1'b1;
            if (front_we)
                front_reg[qid_reg] <= front_wd;
            if (back_we)
                back_reg[qid_reg] <= back_wd;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            qid_reg    <= queue_id;
            handle_reg <= item_handle;
            key_reg    <= item_key;
            type_reg   <= item_type;
        end
        n_reg          <= n_next;
        cur_reg        <= cur_next;
        pv_reg         <= pv_next;
        steps_reg      <= steps_next;
        status_reg     <= status_next;
        out_handle_reg <= out_handle_next;
        out_type_reg   <= out_type_next;
    end

    // node memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (nx_we)
            next_mem[nx_wa] <= nx_wd;
        if (pv_we)
            prev_mem[pv_wa] <= pv_wd;
        if (dat_we)
        begin
            key_mem[n_reg[IDX_W-1:0]]    <= key_reg;
            handle_mem[n_reg[IDX_W-1:0]] <= handle_reg;
            type_mem[n_reg[IDX_W-1:0]]   <= type_reg;
        end
        ra_reg        <= rd_addr;
        next_rd_reg   <= next_mem[rd_addr];
        prev_rd_reg   <= prev_mem[rd_addr];
        key_rd_reg    <= key_mem[rd_addr];
        handle_rd_reg <= handle_mem[rd_addr];
        type_rd_reg   <= type_mem[rd_addr];
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign status     = status_reg;
    assign out_handle = out_handle_reg;
    assign out_type   = out_type_reg;

    // checks
    a_done_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(start))
        else $error("result without a command");

    a_walk_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> func_reg == FN_ENQUEUE)
        else $error("walk during dequeue");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> out_handle == '0 && out_type == '0)
        else $error("payload on failed command");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> steps_reg < NIL)
        else $error("walk past pool size");

endmodule
`default_nettype wire

// ===== tb/multi_queue_manager_sorted_test.sv =====
`default_nettype none

// predicts the node pool and the queues, and holds the results still to come
class queue_pool_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [7:0]  kind;
    } answer_t;

    mqm_pkg::ptr_t node_nxt [mqm_pkg::POOL_NODES];
    mqm_pkg::ptr_t node_prv [mqm_pkg::POOL_NODES];
    logic [15:0]   node_hdl [mqm_pkg::POOL_NODES];
    logic [30:0]   node_key [mqm_pkg::POOL_NODES];
    logic [7:0]    node_typ [mqm_pkg::POOL_NODES];
    mqm_pkg::ptr_t free_top;
    mqm_pkg::ptr_t q_front [mqm_pkg::NUM_QUEUES];
    mqm_pkg::ptr_t q_back [mqm_pkg::NUM_QUEUES];
    logic [7:0]    order_mask;
    answer_t       pending [$];
    int            errors;

    function new();
        errors = 0;
        order_mask = 8'h01;
        free_top = mqm_pkg::NIL - mqm_pkg::ptr_t'(1);
        for (int i = 0; i < mqm_pkg::POOL_NODES; i++)
        begin
            node_nxt[i] = (i == 0) ? mqm_pkg::NIL : mqm_pkg::ptr_t'(i - 1);
            node_prv[i] = mqm_pkg::NIL;
            node_hdl[i] = '0;
            node_key[i] = '0;
            node_typ[i] = '0;
        end
        for (int i = 0; i < mqm_pkg::NUM_QUEUES; i++)
        begin
            q_front[i] = mqm_pkg::NIL;
            q_back[i] = mqm_pkg::NIL;
        end
    endfunction

    function void set_mask(logic [7:0] m);
        order_mask = m;
    endfunction

    // take a free node and link it in, at the back or by key
    function logic [1:0] link_item(logic [2:0] q, logic [15:0] h, logic [30:0] k,
                                   logic [7:0] t);
        mqm_pkg::ptr_t n, cur, pv;
        mqm_pkg::idx_t ni, ci;
        int steps;
        if (free_top == mqm_pkg::NIL)
            return mqm_pkg::ST_NO_FREE;
        n = free_top;
        ni = n[mqm_pkg::IDX_W-1:0];
        free_top = node_nxt[ni];
        node_hdl[ni] = h;
        node_key[ni] = k;
        node_typ[ni] = t;
        cur = mqm_pkg::NIL;
        if (order_mask[q])
        begin
            cur = q_front[q];
            steps = 0;
            while (cur != mqm_pkg::NIL && steps < mqm_pkg::POOL_NODES &&
                   node_key[cur[mqm_pkg::IDX_W-1:0]] <= k)
            begin
                cur = node_nxt[cur[mqm_pkg::IDX_W-1:0]];
                steps++;
            end
            if (steps >= mqm_pkg::POOL_NODES)
                cur = mqm_pkg::NIL;
        end
        if (cur == mqm_pkg::NIL)
        begin
            node_prv[ni] = q_back[q];
            node_nxt[ni] = mqm_pkg::NIL;
            if (q_back[q] != mqm_pkg::NIL)
                node_nxt[q_back[q][mqm_pkg::IDX_W-1:0]] = n;
            else
                q_front[q] = n;
            q_back[q] = n;
        end
        else
        begin
            ci = cur[mqm_pkg::IDX_W-1:0];
            pv = node_prv[ci];
            node_nxt[ni] = cur;
            node_prv[ni] = pv;
            if (pv != mqm_pkg::NIL)
                node_nxt[pv[mqm_pkg::IDX_W-1:0]] = n;
            else
                q_front[q] = n;
            node_prv[ci] = n;
        end
        return mqm_pkg::ST_OK;
    endfunction

    // note an accepted command word and queue up its answer
    function void note_command(logic fn, logic [2:0] q, logic [15:0] h, logic [30:0] k,
                               logic [7:0] t);
        answer_t a;
        mqm_pkg::ptr_t n, nx;
        a = '0;
        if (fn == mqm_pkg::FN_ENQUEUE)
            a.status = link_item(q, h, k, t);
        else if (q_front[q] == mqm_pkg::NIL)
            a.status = mqm_pkg::ST_EMPTY;
        else
        begin
            n = q_front[q];
            a.status = mqm_pkg::ST_OK;
            a.handle = node_hdl[n[mqm_pkg::IDX_W-1:0]];
            a.kind = node_typ[n[mqm_pkg::IDX_W-1:0]];
            nx = node_nxt[n[mqm_pkg::IDX_W-1:0]];
            q_front[q] = nx;
            if (nx != mqm_pkg::NIL)
                node_prv[nx[mqm_pkg::IDX_W-1:0]] = mqm_pkg::NIL;
            else
                q_back[q] = mqm_pkg::NIL;
            node_prv[n[mqm_pkg::IDX_W-1:0]] = mqm_pkg::NIL;
            node_nxt[n[mqm_pkg::IDX_W-1:0]] = free_top;
            free_top = n;
        end
        pending.push_back(a);
    endfunction

    // compare a result word with the oldest answer
    function void check_result(logic [1:0] st, logic [15:0] h, logic [7:0] t);
        answer_t a;
        if (pending.size() == 0)
        begin
            $error("unexpected result word: status %0d handle %0h type %0h", st, h, t);
            errors++;
            return;
        end
        a = pending.pop_front();
        if (st !== a.status)
        begin
            $error("status: expected %0d, actual %0d", a.status, st);
            errors++;
        end
        if (h !== a.handle)
        begin
            $error("out_handle: expected %0h, actual %0h", a.handle, h);
            errors++;
        end
        if (t !== a.kind)
        begin
            $error("out_type: expected %0h, actual %0h", a.kind, t);
            errors++;
        end
    endfunction
endclass

module multi_queue_manager_sorted_test;
    import mqm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        func = 1'b0;
    logic [2:0]  queue_id = '0;
    logic [15:0] item_handle = '0;
    logic [30:0] item_key = '0;
    logic [7:0]  item_type = '0;
    logic        ordered_queue_mask_we = 1'b0;
    logic [7:0]  ordered_queue_mask = '0;
    logic        done;
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [7:0]  out_type;

    queue_pool_scoreboard pool_sb;
    int idle_pct = 0;
    int quiet_cycles = 0;

    multi_queue_manager_sorted uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .queue_id(queue_id),
        .item_handle(item_handle),
        .item_key(item_key),
        .item_type(item_type),
        .ordered_queue_mask_we(ordered_queue_mask_we),
        .ordered_queue_mask(ordered_queue_mask),
        .done(done),
        .status(status),
        .out_handle(out_handle),
        .out_type(out_type)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result words
    always @(posedge clk)
    begin
        if (rst_n && done)
            pool_sb.check_result(status, out_handle, out_type);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // send one command word, with random gaps ahead of it
    task automatic send_cmd(logic fn, logic [2:0] q, logic [15:0] h, logic [30:0] k,
                            logic [7:0] t);
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        func = fn;
        queue_id = q;
        item_handle = h;
        item_key = k;
        item_type = t;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        pool_sb.note_command(fn, q, h, k, t);
        @(negedge clk);
        start = 1'b0;
    endtask

    // mask write once every answer is in and the block has settled
    task automatic write_mask(logic [7:0] m);
        while (pool_sb.pending.size() != 0)
            @(negedge clk);
        repeat (POOL_NODES + 8) @(negedge clk);
        ordered_queue_mask = m;
        ordered_queue_mask_we = 1'b1;
        @(negedge clk);
        ordered_queue_mask_we = 1'b0;
        pool_sb.set_mask(m);
    endtask

    // random key: mostly a narrow range so equal keys are common
    function automatic logic [30:0] pick_key();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2, 3: return 31'($urandom);
            default: return 31'($urandom_range(15));
        endcase
    endfunction

    // random phase: enq_pct sets how full the pool runs
    task automatic random_phase(int count, int enq_pct);
        logic [2:0] q;
        for (int i = 0; i < count; i++)
        begin
            q = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
            send_cmd(($urandom_range(99) < enq_pct) ? FN_ENQUEUE : FN_DEQUEUE, q,
                     16'($urandom), pick_key(), 8'($urandom));
        end
    endtask

    initial
    begin
        pool_sb = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty queues, key extremes, equal keys, fifo order
        send_cmd(FN_DEQUEUE, 3'd0, 16'hFFFF, '1, 8'hFF);
        send_cmd(FN_DEQUEUE, 3'd7, 16'h0, '0, 8'h0);
        send_cmd(FN_ENQUEUE, 3'd0, 16'hFFFF, 31'h7FFFFFFF, 8'hFF);
        send_cmd(FN_ENQUEUE, 3'd0, 16'h0000, 31'h0, 8'h00);
        send_cmd(FN_ENQUEUE, 3'd0, 16'h1111, 31'h5, 8'h11);
        send_cmd(FN_ENQUEUE, 3'd0, 16'h2222, 31'h5, 8'h22);
        send_cmd(FN_ENQUEUE, 3'd0, 16'h3333, 31'h7FFFFFFF, 8'h33);
        send_cmd(FN_ENQUEUE, 3'd7, 16'hAAAA, 31'h9, 8'hAA);
        send_cmd(FN_ENQUEUE, 3'd7, 16'h5555, 31'h1, 8'h55);
        for (int i = 0; i < 6; i++)
            send_cmd(FN_DEQUEUE, 3'd0, 16'h0, '0, 8'h0);
        send_cmd(FN_DEQUEUE, 3'd7, 16'h0, '0, 8'h0);
        send_cmd(FN_DEQUEUE, 3'd7, 16'h0, '0, 8'h0);
        send_cmd(FN_DEQUEUE, 3'd7, 16'h0, '0, 8'h0);

        // random phases over masks and sender gaps
        idle_pct = 0;
        random_phase(150, 70);
        idle_pct = 51;
        random_phase(100, 40);
        write_mask(8'hFF);
        idle_pct = 0;
        random_phase(150, 75);
        idle_pct = 18;
        random_phase(100, 35);
        write_mask(8'h00);
        idle_pct = 51;
        random_phase(150, 65);
        write_mask(8'($urandom));
        idle_pct = 0;
        random_phase(150, 55);
        write_mask(8'hA5);
        idle_pct = 18;
        random_phase(150, 70);
        random_phase(60, 20);

        // drain
        while (pool_sb.pending.size() != 0)
            @(negedge clk);
        repeat (POOL_NODES + 8) @(negedge clk);
        if (pool_sb.errors == 0 && pool_sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

`default_nettype wire
